@@ rtl/twr_pkg.sv @@
// Shared types and constants for the three-wire register access master.
`timescale 1ns / 1ps
`default_nettype none

package twr_pkg;

	localparam int unsigned ADDR_BITS = 7;
	localparam int unsigned DATA_BITS = 8;
	localparam int unsigned FRAME_BITS = ADDR_BITS + 1 + DATA_BITS;
	localparam int unsigned PHASE_BITS = 5;

	localparam logic [PHASE_BITS-1:0] LAST_TICK = 5'd31;

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef struct packed {
		logic                  active;
		logic [PHASE_BITS-1:0] phase;
		logic [FRAME_BITS-1:0] out_shift;
		logic                  is_read;
		logic [DATA_BITS-1:0]  in_shift;
	} state_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] address;
		logic [DATA_BITS-1:0] write_data;
		logic                 data_pin_in;
	} tick_in_t;

	typedef struct packed {
		logic                 rejected;
		logic                 done_res;
		logic [DATA_BITS-1:0] read_value;
		logic                 busy_res;
		logic                 data_line_drive;
		logic                 data_line_out;
		logic                 clock_line;
		logic                 latch_line;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/twr_step.sv @@
// Per-tick access sequencing: next state and pin levels from the current state and one request.
`timescale 1ns / 1ps
`default_nettype none

module twr_step import twr_pkg::*; (
	input  wire logic [1:0] command,
	input  wire tick_in_t   tick_in,
	input  wire state_t     state,
	output state_t          state_next,
	output result_t         result
);

	logic                  start;
	logic                  rd;
	logic [FRAME_BITS-1:0] osh;
	logic [DATA_BITS-1:0]  ish;
	logic [DATA_BITS-1:0]  ish_n;
	logic [PHASE_BITS-1:0] t;
	logic [3:0]            bit_idx;
	logic                  high_half;
	logic                  data_phase;
	logic                  done;

	always_comb begin
		start = (command == CMD_WRITE) || (command == CMD_READ);

		// a start on an idle tick loads the frame and is already tick zero
		if (!state.active) begin
			rd  = (command == CMD_READ);
			osh = {tick_in.address, ~rd, rd ? {DATA_BITS{1'b0}} : tick_in.write_data};
			ish = '0;
			t   = '0;
		end else begin
			rd  = state.is_read;
			osh = state.out_shift;
			ish = state.in_shift;
			t   = state.phase;
		end

		bit_idx    = t[PHASE_BITS-1:1];
		high_half  = t[0];
		data_phase = bit_idx[3];
		done       = (t == LAST_TICK);

		ish_n = ish;
		if (rd && data_phase && !high_half) begin
			ish_n = {ish[DATA_BITS-2:0], tick_in.data_pin_in};
		end

		result                 = '0;
		result.latch_line      = data_phase;
		result.clock_line      = high_half;
		result.busy_res        = 1'b1;
		result.done_res        = done;
		result.rejected        = state.active && start;
		result.read_value      = (done && rd) ? ish_n : '0;
		if (rd && data_phase) begin
			result.data_line_drive = 1'b0;
			result.data_line_out   = 1'b0;
		end else begin
			result.data_line_drive = 1'b1;
			result.data_line_out   = osh[~bit_idx];
		end

		state_next.active    = !done;
		state_next.phase     = t + 5'd1;
		state_next.out_shift = osh;
		state_next.is_read   = rd;
		state_next.in_shift  = ish_n;

		// idle with no start: hold state, park all lines high
		if (!state.active && !start) begin
			state_next             = state;
			result                 = '0;
			result.latch_line      = 1'b1;
			result.clock_line      = 1'b1;
			result.data_line_out   = 1'b1;
			result.data_line_drive = 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/three_wire_register_access_master.sv @@
// Top level of the three-wire register access master: input register, access state, result register.
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------------
//  s_*      | in  | one tick request: tuser command, tdata address/data/pin level
//  m_*      | out | one tick result: pin levels, drive, busy, read byte, done, rejected
//
// One request per clock while m_tready does not stall; a request passes through the input
// register, then the step logic, then the result register on its way to m_*.
// The step logic between the access state and the result register is combinational.
// Reset clears the access state to idle and empties both registers.
// A stalled m_tready holds the result register and then the input register.
`timescale 1ns / 1ps
`default_nettype none

module three_wire_register_access_master import twr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [6:0] address, [14:7] write_data, [15] data_pin_in
	input  wire logic [1:0]  s_tuser,  // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // [0] latch_line, [1] clock_line, [2] data_line_out,
	                                   // [3] data_line_drive, [4] busy_res, [12:5] read_value,
	                                   // [13] done_res, [14] rejected, [15] zero
);

	logic       valid_s1;
	logic [1:0] command_s1;
	tick_in_t   tick_s1;
	result_t    result_s2;
	state_t     state_q;
	state_t     state_next;
	result_t    result;
	logic       advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1          <= s_tuser;
			tick_s1.address     <= s_tdata[6:0];
			tick_s1.write_data  <= s_tdata[14:7];
			tick_s1.data_pin_in <= s_tdata[15];
		end
	end

	twr_step u_step (
		.command    (command_s1),
		.tick_in    (tick_s1),
		.state      (state_q),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			m_tvalid <= 1'b0;
		end else if (advance) begin
			state_q  <= state_next;
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tdata = {1'b0, result_s2};

endmodule

`default_nettype wire

@@ rtl/twr_checker.sv @@
// Port-level checks for the three-wire register access master, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module twr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// idle ticks park all lines high and report nothing
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[3:0] == 4'hF && m_tdata[15:5] == 11'd0)
		else $error("idle tick with wrong pin levels or status");

	// a collected byte appears only on the final tick
	a_rval: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12:5] != 8'd0 |-> m_tdata[13] && m_tdata[4])
		else $error("read byte outside final tick");

	// the data line is released only in the data phase, and then reads low
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[0] && !m_tdata[2] && m_tdata[4])
		else $error("data line released outside a read data phase");

	// the final tick of an access is a clock-high tick with the latch up
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tdata[1] && m_tdata[0])
		else $error("done on a wrong tick");

endmodule

bind three_wire_register_access_master twr_checker u_twr_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the three-wire register access master.
`timescale 1ns / 1ps

module tb;
	import twr_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;  // undefined command, acts as a plain tick
	localparam int QUIET_ITEMS = 200;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] address;
		logic [7:0] write_data;
		logic       data_pin_in;
	} tick_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;

	three_wire_register_access_master i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	tick_req_t tick_q[$];
	result_t pin_levels_q[$];
	int errors = 0;
	logic req_taken = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;

	// shadow of the access state
	logic [5:0] shadow_phase = '0;
	logic [15:0] shadow_frame = '0;
	logic shadow_read = 1'b0;
	logic [7:0] shadow_collect = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic result_t next_pin_levels(tick_req_t req);
		result_t r;
		logic start;
		logic [4:0] t;
		logic [3:0] bit_idx;
		logic go;
		r = '0;
		go = 1'b1;
		start = (req.command == CMD_WRITE) || (req.command == CMD_READ);
		t = shadow_phase[4:0];
		if (shadow_phase == 0) begin
			if (!start) begin
				r.latch_line = 1'b1;
				r.clock_line = 1'b1;
				r.data_line_out = 1'b1;
				r.data_line_drive = 1'b1;
				go = 1'b0;
			end else begin
				shadow_read = (req.command == CMD_READ);
				shadow_frame = {req.address, !shadow_read,
					shadow_read ? 8'h00 : req.write_data};
				shadow_collect = '0;
				t = '0;
			end
		end else begin
			r.rejected = start;
		end
		if (go) begin
			bit_idx = t[4:1];
			r.clock_line = t[0];
			r.latch_line = (bit_idx > 4'd7);
			if (shadow_read && bit_idx > 4'd7) begin
				r.data_line_drive = 1'b0;
				r.data_line_out = 1'b0;
				if (!t[0])
					shadow_collect = {shadow_collect[6:0], req.data_pin_in};
			end else begin
				r.data_line_drive = 1'b1;
				r.data_line_out = shadow_frame[4'd15 - bit_idx];
			end
			r.busy_res = 1'b1;
			r.done_res = (t == LAST_TICK);
			r.read_value = (r.done_res && shadow_read) ? shadow_collect : 8'h00;
			shadow_phase = r.done_res ? 6'd0 : {1'b0, t} + 6'd1;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endfunction

	function automatic void add_tick(logic [1:0] cmd, logic [6:0] addr, logic [7:0] wdata,
			logic pin);
		tick_q.push_back('{command: cmd, address: addr, write_data: wdata, data_pin_in: pin});
	endfunction

	// one access of 32 ticks; pin_sel 0/1 fixes the pin, 2 randomizes it
	function automatic void add_access(logic [1:0] cmd, logic [6:0] addr, logic [7:0] wdata,
			int pin_sel, int noise_pct);
		logic [1:0] c;
		logic pin;
		for (int k = 0; k < 32; k++) begin
			pin = (pin_sel == 2) ? 1'($urandom) : 1'(pin_sel);
			if (k == 0) begin
				add_tick(cmd, addr, wdata, pin);
			end else begin
				c = CMD_TICK;
				if ($urandom_range(0, 99) < noise_pct)
					c = 2'($urandom_range(1, 3));
				add_tick(c, 7'($urandom), 8'($urandom), pin);
			end
		end
	endfunction

	// driver: present requests at the falling edge
	always @(negedge clk) begin
		tick_req_t req;
		logic quiet;
		quiet = (tick_q.size() < QUIET_ITEMS);
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 3);
				s_tvalid <= 1'b0;
			end else if (tick_q.size() > 0) begin
				req = tick_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= req.command;
				s_tdata <= {req.data_pin_in, req.write_data, req.address};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		if (recv_stall > 0) begin
			recv_stall--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			recv_stall = $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		result_t act_r;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				pin_levels_q.push_back(next_pin_levels(
					'{command: s_tuser, address: s_tdata[6:0], write_data: s_tdata[14:7],
					  data_pin_in: s_tdata[15]}));
			if (m_tvalid && m_tready) begin
				if (pin_levels_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				end else begin
					exp_r = pin_levels_q.pop_front();
					act_r = result_t'(m_tdata[14:0]);
					check_field("latch_line", 8'(exp_r.latch_line), 8'(act_r.latch_line));
					check_field("clock_line", 8'(exp_r.clock_line), 8'(act_r.clock_line));
					check_field("data_line_out", 8'(exp_r.data_line_out),
						8'(act_r.data_line_out));
					check_field("data_line_drive", 8'(exp_r.data_line_drive),
						8'(act_r.data_line_drive));
					check_field("busy_res", 8'(exp_r.busy_res), 8'(act_r.busy_res));
					check_field("read_value", exp_r.read_value, act_r.read_value);
					check_field("done_res", 8'(exp_r.done_res), 8'(act_r.done_res));
					check_field("rejected", 8'(exp_r.rejected), 8'(act_r.rejected));
					check_field("pad", 8'h00, 8'(m_tdata[15]));
				end
			end
		end
	end

	initial begin
		int kind;
		// directed: idle ticks, extreme accesses, starts while busy
		add_tick(CMD_TICK, 7'h00, 8'h00, 1'b0);
		add_tick(CMD_NONE, 7'h7f, 8'hff, 1'b1);
		add_access(CMD_WRITE, 7'h7f, 8'hff, 2, 25);
		add_access(CMD_READ, 7'h00, 8'hff, 1, 0);
		add_access(CMD_WRITE, 7'h00, 8'h00, 0, 0);
		add_access(CMD_READ, 7'h7f, 8'h00, 0, 10);
		add_tick(CMD_NONE, 7'h00, 8'h00, 1'b0);
		// random: mostly whole accesses, some idle noise between them
		while (tick_q.size() < 1500) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				add_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 7'($urandom),
					8'($urandom), 2, ($urandom_range(0, 2) == 0) ? 15 : 0);
			end else begin
				repeat ($urandom_range(1, 5))
					add_tick($urandom_range(0, 1) ? CMD_TICK : CMD_NONE, 7'($urandom),
						8'($urandom), 1'($urandom));
			end
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (tick_q.size() == 0);
		@(posedge clk);
		while (s_tvalid) @(posedge clk);
		while (pin_levels_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
